// ----- rtl/lsf_pkg.sv -----
// Shared types, codes and constants of the line substring filter.
// No dependencies; every other file of the block imports this package.
package lsf_pkg;

  localparam int MAX_LINE_DEF    = 1024;
  localparam int MAX_PATTERN_DEF = 16;
  localparam int WIN             = 16;
  localparam int LEN_W           = 11;
  localparam int PAT_LEN_W       = 5;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 2;

  localparam logic [7:0] NEWLINE = 8'h0A;
  localparam logic [7:0] NUL     = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    CMD_DATA = 1'b0,
    CMD_EOS  = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic             line_matched;
    logic [LEN_W-1:0] line_length;
    logic             append_newline;
  } out_item_t;

  typedef struct packed {
    logic [WIN-1:0][7:0]  bytes;
    logic [PAT_LEN_W-1:0] eff_len;
  } pat_cfg_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

// ----- rtl/lsf_in_if.sv -----
// Input byte channel of the line substring filter: valid, ready and payload.
// Depends on lsf_pkg for the payload type.
interface lsf_in_if;
  import lsf_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/lsf_out_if.sv -----
// Result channel of the line substring filter: valid, ready and payload.
// Depends on lsf_pkg for the payload type.
interface lsf_out_if;
  import lsf_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/line_substring_filter.sv -----
// Top level of the line substring filter: pattern registers, line state and
// result register. Depends on lsf_pkg, lsf_in_if, lsf_out_if and submodules.
//
//   channel       direction  payload
//   byte_chan     in         cmd, data_byte
//   result_chan   out        line_matched, line_length, append_newline
//   wr_*          in         pattern_low, pattern_high, pattern_length
//
// One byte is taken per cycle unless stalled; a result appears in the cycle
// after the transfer of the newline or end-of-stream item that closes a line.
// The window compare and the line state update sit between the line state
// registers and the result register, so no item waits on another.
// A byte is refused only while a result is held and the sink is not ready.
// Reset clears the pattern registers, the line state and the result valid.
module line_substring_filter #(
  parameter int MAX_LINE    = lsf_pkg::MAX_LINE_DEF,
  parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lsf_in_if.sink                        byte_chan,
  lsf_out_if.source                     result_chan,
  input  logic                          wr_en,
  input  logic [lsf_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [lsf_pkg::CFG_W-1:0]     wr_data
);
  import lsf_pkg::*;

  pat_cfg_t pat;
  result_t  res;
  logic     can_take;
  logic     accept;

  assign byte_chan.ready = can_take;
  assign accept          = byte_chan.valid && can_take;

  lsf_cfg #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .pat     (pat)
  );

  lsf_scan #(
    .MAX_LINE(MAX_LINE)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (byte_chan.data),
    .pat   (pat),
    .res   (res)
  );

  lsf_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .res     (res),
    .can_take(can_take),
    .tx      (result_chan)
  );

endmodule

// ----- rtl/lsf_cfg.sv -----
// Pattern registers and the effective pattern length derived from them.
// Depends on lsf_pkg.
module lsf_cfg #(
  parameter int MAX_PATTERN = lsf_pkg::MAX_PATTERN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [lsf_pkg::CFG_W-1:0]       wr_data,
  output lsf_pkg::pat_cfg_t               pat
);
  import lsf_pkg::*;

  logic [CFG_W-1:0]     pattern_low;
  logic [CFG_W-1:0]     pattern_high;
  logic [PAT_LEN_W-1:0] pattern_length;
  logic [PAT_LEN_W-1:0] capped_len;
  logic [PAT_LEN_W-1:0] eff_len;
  logic [WIN-1:0][7:0]  bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_PATTERN_LOW:    pattern_low    <= wr_data;
        REG_PATTERN_HIGH:   pattern_high   <= wr_data;
        REG_PATTERN_LENGTH: pattern_length <= wr_data[PAT_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // The pattern ends at its first NUL byte within the capped length.
  always_comb begin
    bytes      = {pattern_high, pattern_low};
    capped_len = (pattern_length > PAT_LEN_W'(MAX_PATTERN)) ?
                 PAT_LEN_W'(MAX_PATTERN) : pattern_length;
    eff_len    = capped_len;
    for (int k = WIN - 1; k >= 0; k--) begin
      if ((PAT_LEN_W'(k) < capped_len) && (bytes[k] == NUL)) begin
        eff_len = PAT_LEN_W'(k);
      end
    end
    pat.bytes   = bytes;
    pat.eff_len = eff_len;
  end

endmodule

// ----- rtl/lsf_scan.sv -----
// Per-line state: the window of recent stored bytes, the stored count and the
// match, NUL and newline flags; forms the result of a line. Depends on lsf_pkg.
module lsf_scan #(
  parameter int MAX_LINE = lsf_pkg::MAX_LINE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  lsf_pkg::in_item_t item,
  input  lsf_pkg::pat_cfg_t pat,
  output lsf_pkg::result_t  res
);
  import lsf_pkg::*;

  localparam int CW = $clog2(MAX_LINE + 1);

  logic [WIN-1:0][7:0]   win;
  logic [CW-1:0]         count;
  logic                  match_seen;
  logic                  nul_seen;
  logic                  last_was_newline;

  logic [WIN-1:0][7:0]   win_next;
  logic [CW-1:0]         count_next;
  logic                  match_seen_next;
  logic                  nul_seen_next;
  logic                  last_was_newline_next;

  logic [WIN-1:0][7:0]   win_shift;
  logic [WIN:0]          hit;
  logic                  is_eos;
  logic                  is_newline;
  logic                  line_done;
  logic [CW+LEN_W-1:0]   count_wide;

  always_comb begin
    is_eos     = (item.cmd == CMD_EOS);
    is_newline = !is_eos && (item.data_byte == NEWLINE);
    line_done  = is_eos || is_newline;
    win_shift  = {item.data_byte, win[WIN-1:1]};

    // A hit for each pattern length, the newest bytes against the pattern.
    hit = '0;
    for (int l = 1; l <= WIN; l++) begin
      hit[l] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (win_shift[WIN-l+k] != pat.bytes[k]) begin
          hit[l] = 1'b0;
        end
      end
    end

    win_next              = win;
    count_next            = count;
    match_seen_next       = match_seen;
    nul_seen_next         = nul_seen;
    last_was_newline_next = last_was_newline;
    if (!is_eos && (count < CW'(MAX_LINE))) begin
      count_next            = count + CW'(1);
      last_was_newline_next = (item.data_byte == NEWLINE);
      if (item.data_byte == NUL) begin
        nul_seen_next = 1'b1;
      end else if (!nul_seen) begin
        win_next = win_shift;
        if (hit[pat.eff_len]) begin
          match_seen_next = 1'b1;
        end
      end
    end

    count_wide              = {{LEN_W{1'b0}}, count_next};
    res.valid               = is_eos ? (count != '0) : is_newline;
    res.item.line_matched   = (pat.eff_len == '0) || match_seen_next;
    res.item.line_length    = count_wide[LEN_W-1:0];
    res.item.append_newline = !last_was_newline_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win              <= '0;
      count            <= '0;
      match_seen       <= 1'b0;
      nul_seen         <= 1'b0;
      last_was_newline <= 1'b0;
    end else if (accept) begin
      if (line_done) begin
        win              <= '0;
        count            <= '0;
        match_seen       <= 1'b0;
        nul_seen         <= 1'b0;
        last_was_newline <= 1'b0;
      end else begin
        win              <= win_next;
        count            <= count_next;
        match_seen       <= match_seen_next;
        nul_seen         <= nul_seen_next;
        last_was_newline <= last_was_newline_next;
      end
    end
  end

endmodule

// ----- rtl/lsf_out_reg.sv -----
// Result register between the line state and the result channel.
// Depends on lsf_pkg and lsf_out_if.
module lsf_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  lsf_pkg::result_t res,
  output logic             can_take,
  lsf_out_if.source        tx
);
  import lsf_pkg::*;

  logic      valid;
  out_item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load && res.valid) begin
      valid <= 1'b1;
    end else if (tx.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      item <= res.item;
    end
  end

  assign can_take = !valid || tx.ready;
  assign tx.valid = valid;
  assign tx.data  = item;

endmodule

// ----- rtl/lsf_checker.sv -----
// Port-level checks of the line substring filter, bound to the top level.
// Depends on lsf_pkg.
module lsf_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input lsf_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_ready,
  input lsf_pkg::out_item_t out_item
);
  import lsf_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_newline_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && (in_item.cmd == CMD_DATA) && (in_item.data_byte == NEWLINE))
    |=> out_valid)
    else $error("Newline transfer gave no result.");

  a_plain_byte_no_result: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && in_xfer && (in_item.cmd == CMD_DATA) &&
     (in_item.data_byte != NEWLINE)) |=> !out_valid)
    else $error("Result without a closing newline or end of stream.");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("Result dropped while stalled.");

  a_out_data_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_item))
    else $error("Result changed while stalled.");

endmodule

bind line_substring_filter lsf_checker u_lsf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (byte_chan.valid),
  .in_ready (byte_chan.ready),
  .in_item  (byte_chan.data),
  .out_valid(result_chan.valid),
  .out_ready(result_chan.ready),
  .out_item (result_chan.data)
);
